// ===== rtl/ddwc_pkg.sv =====
// ============================================================================
// ddwc_pkg - shared types and constants for the wheel command pipeline
// Payload words, register map codes and the fixed-point widths used by the
// top level and the pipelined divider.
// ============================================================================
package ddwc_pkg;

    // 2*pi in Q16, rounded
    localparam int unsigned TWO_PI_Q16 = 411775;

    // APB address width: six 32-bit registers at 4*i
    localparam int CFG_AW = 5;

    // Fixed-point widths
    localparam int DEN_W  = 35;  // 2*pi*radius, Q16 * Q0.16
    localparam int Q1_W   = 38;  // wheel rotation magnitude, Q16 rev/s
    localparam int S_W    = 24;  // safe limit, Q16 rev/s
    localparam int ROT_W  = 25;  // limited rotation, signed Q16
    localparam int NUM_W  = 38;  // scale numerator and denominator
    localparam int PROD_W = 62;  // limit times numerator
    localparam int M_W    = 42;  // max_pps << 18
    localparam int T_W    = 49;  // pwm dividend when in range
    localparam int PQ_W   = 7;   // pwm quotient bits

    localparam logic [7:0] PWM_ZERO = 8'd0;
    localparam logic [7:0] PWM_FULL = 8'd128;

    // Register map
    typedef enum logic [2:0] {
        REG_WHEEL_OFFSET   = 3'd0,
        REG_WHEEL_RADIUS   = 3'd1,
        REG_SAFE_RPS       = 3'd2,
        REG_GEAR_RATIO     = 3'd3,
        REG_PULSES_PER_REV = 3'd4,
        REG_MAX_PPS        = 3'd5
    } t_reg_idx;

    // Input word: velocity command
    typedef struct packed {
        logic signed [15:0] linear_velocity;
        logic signed [15:0] angular_velocity;
    } t_cmd;

    // Output word: drive bytes
    typedef struct packed {
        logic [7:0] right_pwm;
        logic [7:0] left_pwm;
    } t_pwm;

    // Sideband through the scale divider
    typedef struct packed {
        logic signed [ROT_W-1:0] lo;
        logic signed [ROT_W-1:0] ro;
        logic                    sel_l;  // left takes the scaled value
        logic                    sel_r;  // right takes the scaled value
        logic                    neg;    // scaled value is negated
    } t_sat_side;

    // Sideband through the pwm divider
    typedef struct packed {
        logic low;   // below zero: full reverse
        logic high;  // at or above full forward
    } t_pwm_side;

endpackage

// ===== rtl/ddwc_div.sv =====
// ============================================================================
// ddwc_div - pipelined unsigned restoring divider
// One quotient bit per stage, QW stages. The dividend high part (above QW
// bits) must be below the divisor. Divisor and sideband travel with the word.
// ============================================================================
module ddwc_div #(
    parameter int VW = ddwc_pkg::DEN_W,
    parameter int QW = ddwc_pkg::Q1_W,
    parameter int SW = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [VW+QW-1:0] i_dividend,
    input  logic [VW-1:0]    i_divisor,
    input  logic [SW-1:0]    i_side,
    output logic             o_valid,
    output logic [QW-1:0]    o_quot,
    output logic [SW-1:0]    o_side
);

    logic [VW-1:0] r_rem  [QW];
    logic [QW-1:0] r_bits [QW];  // dividend bits shift out, quotient bits shift in
    logic [VW-1:0] r_dvs  [QW];
    logic [SW-1:0] r_side [QW];
    logic          r_vld  [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [VW-1:0] w_rem_in;
        logic [QW-1:0] w_bits_in;
        logic [VW-1:0] w_dvs_in;
        logic [SW-1:0] w_side_in;
        logic          w_vld_in;
        logic [VW:0]   w_shift;
        logic [VW:0]   w_diff;
        logic          w_ge;

        if (k == 0) begin : g_first
            assign w_rem_in  = i_dividend[VW+QW-1:QW];
            assign w_bits_in = i_dividend[QW-1:0];
            assign w_dvs_in  = i_divisor;
            assign w_side_in = i_side;
            assign w_vld_in  = i_valid;
        end else begin : g_next
            assign w_rem_in  = r_rem[k-1];
            assign w_bits_in = r_bits[k-1];
            assign w_dvs_in  = r_dvs[k-1];
            assign w_side_in = r_side[k-1];
            assign w_vld_in  = r_vld[k-1];
        end

        // one trial subtract
        assign w_shift = {w_rem_in, w_bits_in[QW-1]};
        assign w_diff  = w_shift - {1'b0, w_dvs_in};
        assign w_ge    = (w_shift >= {1'b0, w_dvs_in});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= w_vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= w_ge ? w_diff[VW-1:0] : w_shift[VW-1:0];
                r_bits[k] <= {w_bits_in[QW-2:0], w_ge};
                r_dvs[k]  <= w_dvs_in;
                r_side[k] <= w_side_in;
            end
        end
    end

    assign o_valid = r_vld[QW-1];
    assign o_quot  = r_bits[QW-1];
    assign o_side  = r_side[QW-1];

endmodule

// ===== rtl/diff_drive_wheel_command_top.sv =====
// ============================================================================
// diff_drive_wheel_command_top - differential drive wheel command pipeline
// Velocity command to per-wheel rev/s, differential limiting, pulses per
// second and PWM drive bytes, as one fully pipelined datapath.
// ============================================================================
//  channel   | direction | handshake                  | payload
//  ----------+-----------+----------------------------+------------------------
//  command   | in        | i_in_valid / o_in_ready    | i_in_word  (t_cmd)
//  drive     | out       | o_out_valid / i_out_ready  | o_out_word (t_pwm)
//  config    | in        | APB psel/penable/pready    | paddr, pwdata, prdata
//
//  Throughput is one word per cycle unless the output stalls; the depth is set by the
//  three bit-serial divider pipelines (38, 24 and 7 stages) plus 11 datapath stages.
//  A stalled output word freezes the whole pipeline; nothing is dropped.
//  Reset clears the valid bits and loads the register defaults.
//  Registers load at the access phase; derived limits settle in the cycle after.
// ============================================================================
module diff_drive_wheel_command_top (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  ddwc_pkg::t_cmd             i_in_word,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output ddwc_pkg::t_pwm             o_out_word,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ddwc_pkg::CFG_AW-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import ddwc_pkg::*;

    localparam int D1_W = DEN_W + Q1_W;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [15:0] r_wheel_offset, r_wheel_radius, r_safe_rps;
    logic [15:0] r_gear_ratio, r_pulses_per_rev;
    logic [23:0] r_max_pps;
    t_reg_idx    w_reg_idx;

    assign pready    = 1'b1;
    assign w_reg_idx = t_reg_idx'(paddr[4:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wheel_offset   <= 16'd16384;
            r_wheel_radius   <= 16'd4096;
            r_safe_rps       <= 16'd512;
            r_gear_ratio     <= 16'd256;
            r_pulses_per_rev <= 16'd64;
            r_max_pps        <= 24'd10000;
        end else if (psel && penable && pwrite) begin
            unique case (w_reg_idx)
                REG_WHEEL_OFFSET:   r_wheel_offset   <= pwdata[15:0];
                REG_WHEEL_RADIUS:   r_wheel_radius   <= pwdata[15:0];
                REG_SAFE_RPS:       r_safe_rps       <= pwdata[15:0];
                REG_GEAR_RATIO:     r_gear_ratio     <= pwdata[15:0];
                REG_PULSES_PER_REV: r_pulses_per_rev <= pwdata[15:0];
                REG_MAX_PPS:        r_max_pps        <= pwdata[23:0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb begin
        unique case (w_reg_idx)
            REG_WHEEL_OFFSET:   prdata = {16'd0, r_wheel_offset};
            REG_WHEEL_RADIUS:   prdata = {16'd0, r_wheel_radius};
            REG_SAFE_RPS:       prdata = {16'd0, r_safe_rps};
            REG_GEAR_RATIO:     prdata = {16'd0, r_gear_ratio};
            REG_PULSES_PER_REV: prdata = {16'd0, r_pulses_per_rev};
            REG_MAX_PPS:        prdata = {8'd0, r_max_pps};
            default:            prdata = 32'd0;
        endcase
    end

    // derived constants; the user must hold them static while words are in flight, the block has no guard for it
    logic [DEN_W-1:0] r_den;
    logic [S_W-1:0]   r_s;
    logic [M_W-1:0]   r_m;

    always_ff @(posedge i_clk) begin
        r_den <= DEN_W'(TWO_PI_Q16)
               * DEN_W'((r_wheel_radius == 16'd0) ? 16'd1 : r_wheel_radius);
        r_s   <= {r_safe_rps, 8'd0};
        r_m   <= {((r_max_pps == 24'd0) ? 24'd1 : r_max_pps), 18'd0};
    end

    // ------------------------------------------------------------------
    // Pipeline advance: everything moves unless the output word is held
    // ------------------------------------------------------------------
    logic   w_adv;
    logic   r_out_vld;
    t_pwm   r_out_word;

    assign w_adv       = !r_out_vld || i_out_ready;
    assign o_in_ready  = w_adv;
    assign o_out_valid = r_out_vld;
    assign o_out_word  = r_out_word;

    // stage A: input capture
    logic               r_a_vld;
    logic signed [15:0] r_a_v, r_a_w;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)   r_a_vld <= 1'b0;
        else if (w_adv) r_a_vld <= i_in_valid;
    end
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_a_v <= i_in_word.linear_velocity;
            r_a_w <= i_in_word.angular_velocity;
        end
    end

    // stage B: turn term w*offset
    logic               r_b_vld;
    logic signed [15:0] r_b_v;
    logic signed [32:0] r_b_turn;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)   r_b_vld <= 1'b0;
        else if (w_adv) r_b_vld <= r_a_vld;
    end
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_b_v    <= r_a_v;
            r_b_turn <= r_a_w * $signed({1'b0, r_wheel_offset});
        end
    end

    // stage C: wheel numerators, split into sign and magnitude
    logic signed [33:0] w_base, w_turn, w_nl, w_nr, w_absl, w_absr;
    logic               r_c_vld, r_c_negl, r_c_negr;
    logic [31:0]        r_c_magl, r_c_magr;

    assign w_base = {{2{r_b_v[15]}}, r_b_v, 16'd0};
    assign w_turn = {r_b_turn[32], r_b_turn};
    assign w_nl   = w_base + w_turn;
    assign w_nr   = w_base - w_turn;
    assign w_absl = w_nl[33] ? -w_nl : w_nl;
    assign w_absr = w_nr[33] ? -w_nr : w_nr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)   r_c_vld <= 1'b0;
        else if (w_adv) r_c_vld <= r_b_vld;
    end
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_c_negl <= w_nl[33];
            r_c_negr <= w_nr[33];
            r_c_magl <= w_absl[31:0];
            r_c_magr <= w_absr[31:0];
        end
    end

    // rev/s in Q16: (numerator << 24) / (2*pi*radius), per wheel
    logic            w_dl_vld, w_dr_vld, w_dl_neg, w_dr_neg;
    logic [Q1_W-1:0] w_ql, w_qr;

    ddwc_div #(.VW(DEN_W), .QW(Q1_W), .SW(1)) u_div_left (
        .i_clk, .i_rst_n, .i_en(w_adv), .i_valid(r_c_vld),
        .i_dividend({{(D1_W-56){1'b0}}, r_c_magl, 24'd0}),
        .i_divisor(r_den), .i_side(r_c_negl),
        .o_valid(w_dl_vld), .o_quot(w_ql), .o_side(w_dl_neg)
    );

    ddwc_div #(.VW(DEN_W), .QW(Q1_W), .SW(1)) u_div_right (
        .i_clk, .i_rst_n, .i_en(w_adv), .i_valid(r_c_vld),
        .i_dividend({{(D1_W-56){1'b0}}, r_c_magr, 24'd0}),
        .i_divisor(r_den), .i_side(r_c_negr),
        .o_valid(w_dr_vld), .o_quot(w_qr), .o_side(w_dr_neg)
    );

    // stage D: differential saturation decision
    logic signed [39:0] w_l, w_r, w_sl;
    logic signed [39:0] n_lo, n_ro, n_num, n_den;
    logic               n_sel_l, n_sel_r, n_neg;
    logic               r_d_vld;
    t_sat_side          r_d_side;
    logic [NUM_W-1:0]   r_d_num, r_d_den;

    assign w_l  = w_dl_neg ? -$signed({2'b00, w_ql}) : $signed({2'b00, w_ql});
    assign w_r  = w_dr_neg ? -$signed({2'b00, w_qr}) : $signed({2'b00, w_qr});
    assign w_sl = $signed({16'd0, r_s});

    always_comb begin
        n_lo    = w_l;
        n_ro    = w_r;
        n_sel_l = 1'b0;
        n_sel_r = 1'b0;
        n_neg   = 1'b0;
        n_num   = 40'sd0;
        n_den   = 40'sd1;
        if (w_l < 0 && w_r > 0) begin
            n_lo = (w_l < -w_sl) ? -w_sl : w_l;
            n_ro = (w_r > w_sl) ? w_sl : w_r;
        end else if (w_l > 0 && w_r < 0) begin
            n_ro = (w_r < -w_sl) ? -w_sl : w_r;
            n_lo = (w_l > w_sl) ? w_sl : w_l;
        end else if (w_l > w_sl || w_r > w_sl) begin
            n_lo = w_sl;
            n_ro = w_sl;
            if (w_l > w_r) begin
                n_sel_r = 1'b1;
                n_num   = w_l - w_r;
                n_den   = w_l;
            end else if (w_l < w_r) begin
                n_sel_l = 1'b1;
                n_num   = w_r - w_l;
                n_den   = w_r;
            end
        end else if (w_l < -w_sl || w_r < -w_sl) begin
            n_lo  = -w_sl;
            n_ro  = -w_sl;
            n_neg = 1'b1;
            if (w_l < w_r) begin
                n_sel_r = 1'b1;
                n_num   = w_r - w_l;
                n_den   = -w_l;
            end else if (w_l > w_r) begin
                n_sel_l = 1'b1;
                n_num   = w_l - w_r;
                n_den   = -w_r;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)   r_d_vld <= 1'b0;
        else if (w_adv) r_d_vld <= w_dl_vld;
    end
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_d_side.lo    <= n_lo[ROT_W-1:0];
            r_d_side.ro    <= n_ro[ROT_W-1:0];
            r_d_side.sel_l <= n_sel_l;
            r_d_side.sel_r <= n_sel_r;
            r_d_side.neg   <= n_neg;
            r_d_num        <= n_num[NUM_W-1:0];
            r_d_den        <= n_den[NUM_W-1:0];
        end
    end

    // stage E: limit times numerator, two partial products
    logic             r_e_vld;
    t_sat_side        r_e_side;
    logic [NUM_W-1:0] r_e_den;
    logic [42:0]      r_e_plo, r_e_phi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)   r_e_vld <= 1'b0;
        else if (w_adv) r_e_vld <= r_d_vld;
    end
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_e_side <= r_d_side;
            r_e_den  <= r_d_den;
            r_e_plo  <= r_s * r_d_num[18:0];
            r_e_phi  <= r_s * r_d_num[37:19];
        end
    end

    // stage F: combine partial products
    logic              r_f_vld;
    t_sat_side         r_f_side;
    logic [NUM_W-1:0]  r_f_den;
    logic [PROD_W-1:0] r_f_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)   r_f_vld <= 1'b0;
        else if (w_adv) r_f_vld <= r_e_vld;
    end
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_f_side <= r_e_side;
            r_f_den  <= r_e_den;
            r_f_prod <= {r_e_phi, 19'd0} + {19'd0, r_e_plo};
        end
    end

    // scaled wheel: limit * (den - other) / den
    logic           w_sc_vld;
    logic [S_W-1:0] w_sc_q;
    t_sat_side      w_sc_side;

    ddwc_div #(.VW(NUM_W), .QW(S_W), .SW($bits(t_sat_side))) u_div_scale (
        .i_clk, .i_rst_n, .i_en(w_adv), .i_valid(r_f_vld),
        .i_dividend(r_f_prod), .i_divisor(r_f_den), .i_side(r_f_side),
        .o_valid(w_sc_vld), .o_quot(w_sc_q), .o_side(w_sc_side)
    );

    // stage G: final limited rotation per wheel
    logic signed [ROT_W-1:0] w_scl;
    logic                    r_g_vld;
    logic signed [ROT_W-1:0] r_g_lo, r_g_ro;

    assign w_scl = w_sc_side.neg ? -$signed({1'b0, w_sc_q}) : $signed({1'b0, w_sc_q});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)   r_g_vld <= 1'b0;
        else if (w_adv) r_g_vld <= w_sc_vld;
    end
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_g_lo <= w_sc_side.sel_l ? w_scl : w_sc_side.lo;
            r_g_ro <= w_sc_side.sel_r ? w_scl : w_sc_side.ro;
        end
    end

    // stage H: times gear ratio
    logic               r_h_vld;
    logic signed [41:0] r_h_al, r_h_ar;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)   r_h_vld <= 1'b0;
        else if (w_adv) r_h_vld <= r_g_vld;
    end
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_h_al <= r_g_lo * $signed({1'b0, r_gear_ratio});
            r_h_ar <= r_g_ro * $signed({1'b0, r_gear_ratio});
        end
    end

    // stage I: times pulses per revolution, Q24 pulses/s
    logic               r_i_vld;
    logic signed [58:0] r_i_ppsl, r_i_ppsr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)   r_i_vld <= 1'b0;
        else if (w_adv) r_i_vld <= r_h_vld;
    end
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_i_ppsl <= r_h_al * $signed({1'b0, r_pulses_per_rev});
            r_i_ppsr <= r_h_ar * $signed({1'b0, r_pulses_per_rev});
        end
    end

    // stage J: pwm dividend 64*M + pps and range flags (M = max_pps << 18)
    logic signed [58:0] w_m64, w_m128, w_tl, w_tr;
    logic               r_j_vld;
    logic [T_W-1:0]     r_j_tl, r_j_tr;
    t_pwm_side          r_j_sl, r_j_sr;

    assign w_m64  = $signed({11'd0, r_m, 6'd0});
    assign w_m128 = $signed({10'd0, r_m, 7'd0});
    assign w_tl   = w_m64 + r_i_ppsl;
    assign w_tr   = w_m64 + r_i_ppsr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)   r_j_vld <= 1'b0;
        else if (w_adv) r_j_vld <= r_i_vld;
    end
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_j_tl      <= w_tl[T_W-1:0];
            r_j_tr      <= w_tr[T_W-1:0];
            r_j_sl.low  <= w_tl[58];
            r_j_sl.high <= (w_tl >= w_m128);
            r_j_sr.low  <= w_tr[58];
            r_j_sr.high <= (w_tr >= w_m128);
        end
    end

    // pwm quotient per wheel
    logic            w_pl_vld, w_pr_vld;
    logic [PQ_W-1:0] w_pl_q, w_pr_q;
    t_pwm_side       w_pl_side, w_pr_side;

    ddwc_div #(.VW(M_W), .QW(PQ_W), .SW($bits(t_pwm_side))) u_div_pwm_left (
        .i_clk, .i_rst_n, .i_en(w_adv), .i_valid(r_j_vld),
        .i_dividend(r_j_tl), .i_divisor(r_m), .i_side(r_j_sl),
        .o_valid(w_pl_vld), .o_quot(w_pl_q), .o_side(w_pl_side)
    );

    ddwc_div #(.VW(M_W), .QW(PQ_W), .SW($bits(t_pwm_side))) u_div_pwm_right (
        .i_clk, .i_rst_n, .i_en(w_adv), .i_valid(r_j_vld),
        .i_dividend(r_j_tr), .i_divisor(r_m), .i_side(r_j_sr),
        .o_valid(w_pr_vld), .o_quot(w_pr_q), .o_side(w_pr_side)
    );

    // output register with saturation to 0..128
    t_pwm n_out_word;

    always_comb begin
        n_out_word.left_pwm  = w_pl_side.low  ? PWM_ZERO :
                               w_pl_side.high ? PWM_FULL : {1'b0, w_pl_q};
        n_out_word.right_pwm = w_pr_side.low  ? PWM_ZERO :
                               w_pr_side.high ? PWM_FULL : {1'b0, w_pr_q};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)   r_out_vld <= 1'b0;
        else if (w_adv) r_out_vld <= w_pl_vld;
    end
    always_ff @(posedge i_clk) begin
        if (w_adv) r_out_word <= n_out_word;
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // parallel divider lanes stay in step
    a_lanes_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_dl_vld == w_dr_vld) && (w_pl_vld == w_pr_vld))
        else $error("divider lanes out of step");

    // limited rotation never exceeds the safe limit
    a_rot_limited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_g_vld |-> ($signed(r_g_lo) <= $signed({2'b00, r_s}))
                 && ($signed(r_g_lo) >= -$signed({2'b00, r_s}))
                 && ($signed(r_g_ro) <= $signed({2'b00, r_s}))
                 && ($signed(r_g_ro) >= -$signed({2'b00, r_s})))
        else $error("limited rotation beyond safe limit");

    // drive bytes stay within 0..128
    a_pwm_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_word.left_pwm <= PWM_FULL)
                     && (o_out_word.right_pwm <= PWM_FULL))
        else $error("drive byte out of range");

    // reset empties the output
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

// ===== bench/diff_drive_wheel_command_top_tb.sv =====
`timescale 1ns / 100ps
// ============================================================================
// diff_drive_wheel_command_top_tb - self-checking bench for the wheel commands
// Velocity commands are sent through the valid/ready command channel while
// the register set is changed over APB between phases. A behavioral model of
// the kinematics, the differential limiting and the PWM mapping predicts each
// drive word, and every drive word coming out is compared with it in order.
// ============================================================================
module diff_drive_wheel_command_top_tb;
    import ddwc_pkg::*;

    localparam int  CYCLE_LIMIT = 400000;
    localparam int  DRAIN_WAIT  = 100;  // settle time after the last drive word
    localparam longint TWO_PI   = 411775;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    t_cmd        i_in_word;
    logic        o_out_valid;
    logic        i_out_ready;
    t_pwm        o_out_word;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [CFG_AW-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Shadow of the register set
    longint offset_q16, radius_q16, safe_q8, gear_q8, ppr, full_pps;

    t_pwm   drive_queue[$];
    int     mismatches;
    int     words_in, words_out, cfg_writes;
    int     cycles;
    bit     idles_on;
    int     hold_cycles;

    diff_drive_wheel_command_top dut (.*);

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Drive byte from a limited rotation, Q16 rev/s
    function automatic logic [7:0] drive_byte(longint rot);
        longint pps, div, t, q;
        pps = rot * gear_q8 * ppr;
        div = (full_pps == 0 ? 64'sd1 : full_pps) * (64'sd1 <<< 24);
        t   = 64 * div + 64 * pps;
        if (t < 0) return PWM_ZERO;
        q = t / div;
        if (q > 128) return PWM_FULL;
        return q[7:0];
    endfunction

    // Wheel speeds, differential limiting and drive bytes for one command
    function automatic t_pwm wheel_drive(t_cmd c);
        longint v, w, turn, base, den, lim, lw, rw, lo, ro;
        t_pwm   res;
        v    = longint'(c.linear_velocity);
        w    = longint'(c.angular_velocity);
        turn = w * offset_q16;
        base = v * 65536;
        den  = TWO_PI * (radius_q16 == 0 ? 64'sd1 : radius_q16);
        lim  = safe_q8 * 256;
        lw   = ((base + turn) * (64'sd1 <<< 24)) / den;
        rw   = ((base - turn) * (64'sd1 <<< 24)) / den;
        if (lw < 0 && rw > 0) begin
            lo = lw < -lim ? -lim : lw;
            ro = rw > lim ? lim : rw;
        end else if (lw > 0 && rw < 0) begin
            ro = rw < -lim ? -lim : rw;
            lo = lw > lim ? lim : lw;
        end else if (lw > lim || rw > lim) begin
            if (lw > rw) begin
                ro = (lim * (lw - rw)) / lw;
                lo = lim;
            end else if (lw < rw) begin
                lo = (lim * (rw - lw)) / rw;
                ro = lim;
            end else begin
                lo = lim;
                ro = lim;
            end
        end else if (lw < -lim || rw < -lim) begin
            if (lw < rw) begin
                ro = -((lim * (rw - lw)) / -lw);
                lo = -lim;
            end else if (lw > rw) begin
                lo = -((lim * (lw - rw)) / -rw);
                ro = -lim;
            end else begin
                lo = -lim;
                ro = -lim;
            end
        end else begin
            lo = lw;
            ro = rw;
        end
        res.right_pwm = drive_byte(ro);
        res.left_pwm  = drive_byte(lo);
        return res;
    endfunction

    // APB write, setup then access; shadow updated alongside
    task automatic write_reg(t_reg_idx idx, logic [31:0] val);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = CFG_AW'(idx) << 2;
        pwdata  = val;
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        case (idx)
            REG_WHEEL_OFFSET:   offset_q16 = val[15:0];
            REG_WHEEL_RADIUS:   radius_q16 = val[15:0];
            REG_SAFE_RPS:       safe_q8    = val[15:0];
            REG_GEAR_RATIO:     gear_q8    = val[15:0];
            REG_PULSES_PER_REV: ppr        = val[15:0];
            REG_MAX_PPS:        full_pps   = val[23:0];
            default: ;
        endcase
        cfg_writes++;
    endtask

    task automatic write_all(logic [15:0] off, logic [15:0] rad, logic [15:0] safe,
                             logic [15:0] gear, logic [15:0] pulses, logic [23:0] mp);
        write_reg(REG_WHEEL_OFFSET, {16'd0, off});
        write_reg(REG_WHEEL_RADIUS, {16'd0, rad});
        write_reg(REG_SAFE_RPS, {16'd0, safe});
        write_reg(REG_GEAR_RATIO, {16'd0, gear});
        write_reg(REG_PULSES_PER_REV, {16'd0, pulses});
        write_reg(REG_MAX_PPS, {8'd0, mp});
    endtask

    // Send one command word, with random gaps before it while idles_on is set
    task automatic send_cmd(logic [15:0] lin, logic [15:0] ang);
        @(negedge i_clk);
        while (idles_on && $urandom_range(99) < 21) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_word.linear_velocity  = lin;
        i_in_word.angular_velocity = ang;
        do @(posedge i_clk); while (!o_in_ready);
        drive_queue.push_back(wheel_drive(i_in_word));
        words_in++;
    endtask

    // Drop valid and wait until every drive word is back
    task automatic drain;
        @(negedge i_clk);
        i_in_valid = 1'b0;
        wait (drive_queue.size() == 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    // Velocity mixed between full range, the region near the limit and the extremes
    function automatic logic [15:0] rand_vel();
        case ($urandom_range(3))
            0:       return 16'($urandom);
            1:       return 16'($signed($urandom_range(2047)) - 1024);
            2:       return 16'($signed($urandom_range(511)) - 256);
            default: return {$urandom_range(1) ? 16'h8000 : 16'h7fff} ^ 16'($urandom_range(15));
        endcase
    endfunction

    // Extremes, equal wheels, opposite signs, stop
    task automatic test_directed;
        send_cmd(16'h0000, 16'h0000);
        send_cmd(16'h7fff, 16'h0000);
        send_cmd(16'h8000, 16'h0000);
        send_cmd(16'h0000, 16'h7fff);
        send_cmd(16'h0000, 16'h8000);
        send_cmd(16'h7fff, 16'h7fff);
        send_cmd(16'h8000, 16'h8000);
        send_cmd(16'h7fff, 16'h8000);
        send_cmd(16'h8000, 16'h7fff);
        send_cmd(16'h0100, 16'h0000);   // just above the limit, both equal
        send_cmd(16'hff00, 16'h0000);
        send_cmd(16'h00c0, 16'h0000);   // inside the limit
        send_cmd(16'h0200, 16'h0100);   // both wheels over, scaled partner
        send_cmd(16'h0200, 16'hff00);
        send_cmd(16'hfe00, 16'h0100);
        send_cmd(16'hfe00, 16'hff00);
        send_cmd(16'h0040, 16'h0800);   // opposite signs
        send_cmd(16'h0001, 16'hffff);
        send_cmd(16'hffff, 16'h0001);
        send_cmd(16'h5555, 16'haaaa);
        send_cmd(16'haaaa, 16'h5555);
        drain();
    endtask

    // Degenerate registers: zero radius, max_pps, offset, safe limit, gear and pulse count
    task automatic test_zero_regs;
        write_all(16'hffff, 16'd0, 16'hffff, 16'hffff, 16'hffff, 24'd0);
        repeat (8) send_cmd(rand_vel(), rand_vel());
        drain();
        write_all(16'd0, 16'hffff, 16'd0, 16'd0, 16'd64, 24'hffffff);
        repeat (8) send_cmd(rand_vel(), rand_vel());
        drain();
        write_all(16'd16384, 16'd4096, 16'd512, 16'd256, 16'd0, 24'd1);
        repeat (8) send_cmd(rand_vel(), rand_vel());
        drain();
    endtask

    // Random commands over several register settings
    task automatic test_random(int phases, int per_phase);
        for (int p = 0; p < phases; p++) begin
            if (p == 0)
                write_all(16'd16384, 16'd4096, 16'd512, 16'd256, 16'd64, 24'd10000);
            else
                write_all($urandom_range(1) ? 16'($urandom) : 16'($urandom_range(32768)),
                          $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(8192, 1)),
                          $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(2048)),
                          $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(1024, 1)),
                          $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(256, 1)),
                          $urandom_range(1) ? 24'($urandom) : 24'($urandom_range(65535, 1)));
            idles_on = (p != 1);   // one phase runs back to back
            repeat (per_phase) send_cmd(rand_vel(), rand_vel());
            idles_on = 1'b1;
            drain();
        end
    endtask

    // Output held off long enough to fill the pipeline and stall the input
    task automatic test_backpressure;
        idles_on    = 1'b0;
        hold_cycles = 300;
        repeat (150) send_cmd(rand_vel(), rand_vel());
        idles_on = 1'b1;
        drain();
    endtask

    // Output side: random ready, or a counted hold-off
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            i_out_ready = 1'b0;
            hold_cycles--;
        end else begin
            i_out_ready = idles_on ? ($urandom_range(99) >= 21) : 1'b1;
        end
    end

    // Drive word checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            words_out++;
            if (drive_queue.size() == 0) begin
                $error("drive word with none expected: %h", o_out_word);
                mismatches++;
            end else begin
                t_pwm want;
                want = drive_queue.pop_front();
                if (o_out_word.right_pwm !== want.right_pwm) begin
                    $error("right_pwm expected %0d actual %0d",
                           want.right_pwm, o_out_word.right_pwm);
                    mismatches++;
                end
                if (o_out_word.left_pwm !== want.left_pwm) begin
                    $error("left_pwm expected %0d actual %0d",
                           want.left_pwm, o_out_word.left_pwm);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_word   = '0;
        i_out_ready = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        mismatches  = 0;
        words_in    = 0;
        words_out   = 0;
        cfg_writes  = 0;
        cycles      = 0;
        hold_cycles = 0;
        idles_on    = 1'b1;
        offset_q16  = 16384;
        radius_q16  = 4096;
        safe_q8     = 512;
        gear_q8     = 256;
        ppr         = 64;
        full_pps    = 10000;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_zero_regs();
        test_backpressure();
        test_random(8, 80);

        $display("Covered %0d commands, %0d drive words, %0d register writes,",
                 words_in, words_out, cfg_writes);
        $display("including degenerate registers and a long output stall.");
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Anything left over at the end holds the drain wait until the watchdog ends the run
endmodule
